// ===== hw/rtl/toa_pkg.sv =====
package toa_pkg;

	// Fixed option geometry: kind, size, then port and IPv4 address.
	localparam int ADDR_OPTION_SIZE = 8;
	localparam logic [7:0] ADDR_OPTION_SIZE_CODE = 8'(ADDR_OPTION_SIZE);
	localparam logic [2:0] CAPTURE_BYTES = 3'(ADDR_OPTION_SIZE - 2);

	// Well-known option kinds.
	localparam logic [7:0] KIND_EOL = 8'd0;
	localparam logic [7:0] KIND_NOP = 8'd1;

	// Smallest legal option size.
	localparam logic [7:0] MIN_OPTION_SIZE = 8'd2;

	// Input commands.
	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_BYTE   = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_FOUND   = 3'd0;
	localparam logic [2:0] ST_NOSYN   = 3'd1;
	localparam logic [2:0] ST_EOL     = 3'd2;
	localparam logic [2:0] ST_BAD     = 3'd3;
	localparam logic [2:0] ST_NOMATCH = 3'd4;

	// Parser phases.
	typedef enum logic [4:0] {
		PH_DONE = 5'b00001,
		PH_KIND = 5'b00010,
		PH_SIZE = 5'b00100,
		PH_SKIP = 5'b01000,
		PH_CAPT = 5'b10000
	} phase_t;

	// One input beat.
	typedef struct packed {
		logic       command;
		logic       syn_flag;
		logic [5:0] options_length;
		logic [7:0] option_byte;
	} toa_item_t;

	// One result beat.
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] client_port;
		logic [31:0] client_addr;
	} toa_result_t;

endpackage

// ===== hw/rtl/toa_if.sv =====
// Input channel: header and option byte beats.
interface toa_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic       syn_flag;
	logic [5:0] options_length;
	logic [7:0] option_byte;

	modport source (output valid, output command, output syn_flag,
		output options_length, output option_byte, input ready);
	modport sink (input valid, input command, input syn_flag,
		input options_length, input option_byte, output ready);
endinterface

// Result channel: one status beat per segment.
interface toa_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] client_port;
	logic [31:0] client_addr;

	modport source (output valid, output status, output client_port,
		output client_addr, input ready);
	modport sink (input valid, input status, input client_port,
		input client_addr, output ready);
endinterface

// Configuration write channel for the option kind register.
interface toa_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/toa_parser.sv =====
module toa_parser import toa_pkg::*; #(
	parameter int MAX_OPTION_BYTES = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  toa_item_t   item,
	input  logic [7:0]  opt_kind,
	output logic        emit,
	output toa_result_t result
);

	localparam logic [5:0] MaxLen = 6'(MAX_OPTION_BYTES);

	phase_t      phase_q, phase_d;
	logic [5:0]  bytes_left_q, bytes_left_d;
	logic        kind_match_q, kind_match_d;
	logic [5:0]  skip_q, skip_d;
	logic [47:0] capt_q, capt_d;
	logic [2:0]  capt_cnt_q, capt_cnt_d;

	logic [7:0]  b;
	logic [5:0]  len_sat;
	logic [5:0]  bl_dec;
	logic [5:0]  bl_sub;
	logic [5:0]  skip_new;
	logic [5:0]  skip_dec;
	logic [47:0] capt_new;
	logic [2:0]  capt_cnt_inc;

	assign b            = item.option_byte;
	assign len_sat      = (item.options_length > MaxLen) ? MaxLen : item.options_length;
	assign bl_dec       = bytes_left_q - 6'd1;
	assign bl_sub       = bytes_left_q - b[5:0];
	assign skip_new     = b[5:0] - 6'd2;
	assign skip_dec     = skip_q - 6'd1;
	assign capt_new     = {capt_q[39:0], b};
	assign capt_cnt_inc = capt_cnt_q + 3'd1;

	// One step of the option walk for the current beat.
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		kind_match_d = kind_match_q;
		skip_d       = skip_q;
		capt_d       = capt_q;
		capt_cnt_d   = capt_cnt_q;
		emit         = 1'b0;
		result       = '0;

		if (item.command == CMD_HEADER) begin
			kind_match_d = 1'b0;
			skip_d       = '0;
			capt_d       = '0;
			capt_cnt_d   = '0;
			if (!item.syn_flag) begin
				bytes_left_d  = '0;
				emit          = 1'b1;
				result.status = ST_NOSYN;
			end else begin
				bytes_left_d = len_sat;
				if (len_sat == 6'd0) begin
					emit          = 1'b1;
					result.status = ST_NOMATCH;
				end else begin
					phase_d = PH_KIND;
				end
			end
		end else begin
			case (phase_q)
				PH_KIND: begin
					if (b == KIND_EOL) begin
						emit          = 1'b1;
						result.status = ST_EOL;
					end else if (b == KIND_NOP) begin
						bytes_left_d = bl_dec;
						if (bl_dec == 6'd0) begin
							emit          = 1'b1;
							result.status = ST_NOMATCH;
						end
					end else if (bytes_left_q <= 6'd1) begin
						// A kind byte with no room left for its size byte.
						emit          = 1'b1;
						result.status = ST_BAD;
					end else begin
						kind_match_d = (b == opt_kind);
						phase_d      = PH_SIZE;
					end
				end
				PH_SIZE: begin
					if (b < MIN_OPTION_SIZE || b > {2'b00, bytes_left_q}) begin
						emit          = 1'b1;
						result.status = ST_BAD;
					end else if (kind_match_q && b == ADDR_OPTION_SIZE_CODE) begin
						capt_d     = '0;
						capt_cnt_d = '0;
						phase_d    = PH_CAPT;
					end else begin
						bytes_left_d = bl_sub;
						skip_d       = skip_new;
						if (skip_new != 6'd0) begin
							phase_d = PH_SKIP;
						end else if (bl_sub == 6'd0) begin
							emit          = 1'b1;
							result.status = ST_NOMATCH;
						end else begin
							phase_d = PH_KIND;
						end
					end
				end
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == 6'd0) begin
						if (bytes_left_q == 6'd0) begin
							emit          = 1'b1;
							result.status = ST_NOMATCH;
						end else begin
							phase_d = PH_KIND;
						end
					end
				end
				PH_CAPT: begin
					capt_d     = capt_new;
					capt_cnt_d = capt_cnt_inc;
					if (capt_cnt_inc >= CAPTURE_BYTES) begin
						emit               = 1'b1;
						result.status      = ST_FOUND;
						result.client_port = capt_new[47:32];
						result.client_addr = capt_new[31:0];
					end
				end
				default: begin
					// No segment open: the byte is dropped.
				end
			endcase
		end

		if (emit) begin
			phase_d = PH_DONE;
		end
	end

	// Walk state, updated once per consumed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DONE;
			bytes_left_q <= '0;
			kind_match_q <= 1'b0;
			skip_q       <= '0;
			capt_cnt_q   <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			kind_match_q <= kind_match_d;
			skip_q       <= skip_d;
			capt_cnt_q   <= capt_cnt_d;
		end
	end

	// The capture buffer is cleared before use, so it needs no reset.
	always_ff @(posedge clk) begin
		if (step) begin
			capt_q <= capt_d;
		end
	end

endmodule

// ===== hw/rtl/toa_out_stage.sv =====
module toa_out_stage import toa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  toa_result_t data,
	output logic        free,
	toa_out_if.source   results
);

	logic        valid_q;
	toa_result_t data_q;

	// The register can take a new beat when empty or being drained.
	assign free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign results.valid       = valid_q;
	assign results.status      = data_q.status;
	assign results.client_port = data_q.client_port;
	assign results.client_addr = data_q.client_addr;

endmodule

// ===== hw/rtl/tcp_option_address_extractor.sv =====
// A result beat passes through the input register, then the result register.
// Throughput: one input beat per cycle while the result side has room.
// The input register stalls only while the result register holds a beat that
// the sink is not taking in the same cycle.
// Reset (arst_n low, asynchronous) empties both registers, closes any open
// segment and sets the option kind register to 254.
module tcp_option_address_extractor import toa_pkg::*; #(
	parameter int MAX_OPTION_BYTES = 40
) (
	input  logic      clk,
	input  logic      arst_n,
	toa_in_if.sink    items,
	toa_out_if.source results,
	toa_cfg_if.sink   cfg
);

	logic        in_valid_s1;
	toa_item_t   item_s1;
	logic        out_free;
	logic        step;
	logic        emit;
	toa_result_t result;
	logic [7:0]  opt_kind_q;

	// Option kind register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opt_kind_q <= 8'd254;
		end else if (cfg.valid) begin
			opt_kind_q <= cfg.data;
		end
	end

	// Input register; it advances whenever the result side has room.
	assign step        = in_valid_s1 && out_free;
	assign items.ready = !in_valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			in_valid_s1 <= 1'b1;
		end else if (step) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.command        <= items.command;
			item_s1.syn_flag       <= items.syn_flag;
			item_s1.options_length <= items.options_length;
			item_s1.option_byte    <= items.option_byte;
		end
	end

	toa_parser #(
		.MAX_OPTION_BYTES(MAX_OPTION_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (item_s1),
		.opt_kind(opt_kind_q),
		.emit    (emit),
		.result  (result)
	);

	toa_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && emit),
		.data   (result),
		.free   (out_free),
		.results(results)
	);

	// A beat is only consumed when the result register can take its result.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> (!results.valid || results.ready))
		else $error("result register overwritten");

	// Every result carries a defined status code.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.status <= ST_NOMATCH))
		else $error("undefined status code");

	// Port and address are zero unless the option was found.
	a_zero_unless_found: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.status != ST_FOUND) |->
		(results.client_port == 16'd0 && results.client_addr == 32'd0))
		else $error("capture fields set without a match");

	// A new result only follows a consumed beat that decided it.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !$past(results.valid && !results.ready)) |->
		$past(step && emit))
		else $error("result without a deciding beat");

endmodule
